[rtl/srif_pkg.sv]
// shared types, constants and width helpers for the regularized inverse filter
package srif_pkg;

    localparam int CFG_WIDTH = 32;
    localparam logic [CFG_WIDTH-1:0] SCALE_RESET = 32'hFFFF_FFFF;
    localparam logic [CFG_WIDTH-1:0] BETA_SQ_RESET = 32'h0000_0000;

    // register index, taken from byte address bit 2
    typedef enum logic {
        REG_SCALE   = 1'b0,
        REG_BETA_SQ = 1'b1
    } srif_reg_t;

    // per-bin status carried alongside the division chain
    typedef struct packed {
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
        logic zero_den;
    } srif_flags_t;

    // width of the denominator |H|^2 + beta^2
    function automatic int den_width(input int sample_w, input int frac_w);
        int a;
        int b;
        a = 2 * sample_w;
        b = CFG_WIDTH + frac_w;
        return ((a > b) ? a : b) + 1;
    endfunction

endpackage

[rtl/srif_front.sv]
// front pipeline: products, numerator and denominator, scaling, division setup
module srif_front #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         filter_real,
    input  logic signed [SAMPLE_WIDTH-1:0]         filter_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]         signal_real,
    input  logic signed [SAMPLE_WIDTH-1:0]         signal_imag,
    input  logic [srif_pkg::CFG_WIDTH-1:0]         scale_factor,
    input  logic [srif_pkg::CFG_WIDTH-1:0]         regularization_squared,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS)+1:0] rem_re,
    output logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS)+1:0] rem_im,
    output logic [SAMPLE_WIDTH:0]                  low_re,
    output logic [SAMPLE_WIDTH:0]                  low_im,
    output logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS):0]   d2,
    output srif_pkg::srif_flags_t                  flags
);
    import srif_pkg::*;

    localparam int W   = SAMPLE_WIDTH;
    localparam int DW  = den_width(SAMPLE_WIDTH, FRACTION_BITS);
    localparam int RW  = DW + 2;
    localparam int PW  = 2 * W + CFG_WIDTH;
    localparam int SH  = 31 - FRACTION_BITS;
    localparam int XA  = PW - SH;
    localparam int XW  = ((XA > DW) ? XA : DW) + 1;
    localparam int HW  = XW - W - 1;
    localparam int CW  = (HW > DW + 1) ? HW : DW + 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

    // stage 1
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_hh_reg, p_jj_reg;
    // stage 2
    logic signed [2*W:0]   nre_reg, nim_reg;
    logic [DW-1:0]         den2_reg;
    // stage 3
    logic [2*W-1:0]        mag_re_reg, mag_im_reg;
    logic [DW-1:0]         den3_reg;
    srif_flags_t           fl3_reg;
    // stage 4
    logic [W+CFG_WIDTH-1:0] pp_re_lo_reg, pp_re_hi_reg, pp_im_lo_reg, pp_im_hi_reg;
    logic [DW-1:0]         den4_reg;
    srif_flags_t           fl4_reg;
    // stage 5
    logic [PW-1:0]         prod_re_reg, prod_im_reg;
    logic [DW-1:0]         den5_reg;
    srif_flags_t           fl5_reg;
    // stage 6
    logic [XW-1:0]         x_re_reg, x_im_reg;
    logic [DW-1:0]         den6_reg;
    srif_flags_t           fl6_reg;
    // stage 7
    logic [RW-1:0]         rem_re_reg, rem_im_reg;
    logic [W:0]            low_re_reg, low_im_reg;
    logic [DW:0]           d2_reg;
    srif_flags_t           fl7_reg;

    logic signed [2*W:0]   nre_next, nim_next;
    logic [DW-1:0]         den2_next;
    logic [2*W-1:0]        mag_re_next, mag_im_next;
    logic [DW:0]           d2_next;
    logic [HW-1:0]         hi_re, hi_im;
    logic                  ovf_re_next, ovf_im_next;
    srif_flags_t           fl3_next, fl7_next;

    assign adv7 = !v7_reg || out_ready;
    assign adv6 = !v6_reg || adv7;
    assign adv5 = !v5_reg || adv6;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        nre_next  = (2*W+1)'(p_rr_reg) + (2*W+1)'(p_ii_reg);
        nim_next  = (2*W+1)'(p_ri_reg) - (2*W+1)'(p_ir_reg);
        den2_next = DW'(unsigned'(p_hh_reg)) + DW'(unsigned'(p_jj_reg))
                  + (DW'(regularization_squared) << FRACTION_BITS);
    end

    always_comb
    begin
        mag_re_next = nre_reg[2*W] ? (2*W)'(-nre_reg) : nre_reg[2*W-1:0];
        mag_im_next = nim_reg[2*W] ? (2*W)'(-nim_reg) : nim_reg[2*W-1:0];
        fl3_next          = '0;
        fl3_next.neg_re   = nre_reg[2*W];
        fl3_next.neg_im   = nim_reg[2*W];
        fl3_next.zero_den = (den2_reg == '0);
    end

    always_comb
    begin
        d2_next     = {den6_reg, 1'b0};
        hi_re       = x_re_reg[XW-1:W+1];
        hi_im       = x_im_reg[XW-1:W+1];
        ovf_re_next = CW'(hi_re) >= CW'(d2_next);
        ovf_im_next = CW'(hi_im) >= CW'(d2_next);
        fl7_next        = fl6_reg;
        fl7_next.ovf_re = ovf_re_next;
        fl7_next.ovf_im = ovf_im_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
            if (adv7) v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            p_rr_reg <= filter_real * signal_real;
            p_ii_reg <= filter_imag * signal_imag;
            p_ri_reg <= filter_real * signal_imag;
            p_ir_reg <= filter_imag * signal_real;
            p_hh_reg <= filter_real * filter_real;
            p_jj_reg <= filter_imag * filter_imag;
        end
        if (adv2)
        begin
            nre_reg  <= nre_next;
            nim_reg  <= nim_next;
            den2_reg <= den2_next;
        end
        if (adv3)
        begin
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            den3_reg   <= den2_reg;
            fl3_reg    <= fl3_next;
        end
        if (adv4)
        begin
            // split the magnitude so each multiply stays narrow
            pp_re_lo_reg <= (W+CFG_WIDTH)'(mag_re_reg[W-1:0]) * (W+CFG_WIDTH)'(scale_factor);
            pp_re_hi_reg <= (W+CFG_WIDTH)'(mag_re_reg[2*W-1:W]) * (W+CFG_WIDTH)'(scale_factor);
            pp_im_lo_reg <= (W+CFG_WIDTH)'(mag_im_reg[W-1:0]) * (W+CFG_WIDTH)'(scale_factor);
            pp_im_hi_reg <= (W+CFG_WIDTH)'(mag_im_reg[2*W-1:W]) * (W+CFG_WIDTH)'(scale_factor);
            den4_reg     <= den3_reg;
            fl4_reg      <= fl3_reg;
        end
        if (adv5)
        begin
            prod_re_reg <= (PW'(pp_re_hi_reg) << W) + PW'(pp_re_lo_reg);
            prod_im_reg <= (PW'(pp_im_hi_reg) << W) + PW'(pp_im_lo_reg);
            den5_reg    <= den4_reg;
            fl5_reg     <= fl4_reg;
        end
        if (adv6)
        begin
            // rounding offset folded in as +D against a divisor of 2D
            x_re_reg <= XW'(prod_re_reg >> SH) + XW'(den5_reg);
            x_im_reg <= XW'(prod_im_reg >> SH) + XW'(den5_reg);
            den6_reg <= den5_reg;
            fl6_reg  <= fl5_reg;
        end
        if (adv7)
        begin
            rem_re_reg <= RW'(hi_re);
            rem_im_reg <= RW'(hi_im);
            low_re_reg <= x_re_reg[W:0];
            low_im_reg <= x_im_reg[W:0];
            d2_reg     <= d2_next;
            fl7_reg    <= fl7_next;
        end
    end

    assign out_valid = v7_reg;
    assign rem_re    = rem_re_reg;
    assign rem_im    = rem_im_reg;
    assign low_re    = low_re_reg;
    assign low_im    = low_im_reg;
    assign d2        = d2_reg;
    assign flags     = fl7_reg;

endmodule

[rtl/srif_div_cell.sv]
// one restoring-division cell: one quotient bit for each part per transaction
module srif_div_cell #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS)+1:0] in_rem_re,
    input  logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS)+1:0] in_rem_im,
    input  logic [SAMPLE_WIDTH:0]                  in_low_re,
    input  logic [SAMPLE_WIDTH:0]                  in_low_im,
    input  logic [SAMPLE_WIDTH:0]                  in_q_re,
    input  logic [SAMPLE_WIDTH:0]                  in_q_im,
    input  logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS):0]   in_d2,
    input  srif_pkg::srif_flags_t                  in_flags,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS)+1:0] out_rem_re,
    output logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS)+1:0] out_rem_im,
    output logic [SAMPLE_WIDTH:0]                  out_low_re,
    output logic [SAMPLE_WIDTH:0]                  out_low_im,
    output logic [SAMPLE_WIDTH:0]                  out_q_re,
    output logic [SAMPLE_WIDTH:0]                  out_q_im,
    output logic [srif_pkg::den_width(SAMPLE_WIDTH, FRACTION_BITS):0]   out_d2,
    output srif_pkg::srif_flags_t                  out_flags
);
    import srif_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int DW = den_width(SAMPLE_WIDTH, FRACTION_BITS);
    localparam int RW = DW + 2;

    logic          valid_reg;
    logic          adv;
    logic [RW-1:0] sh_re, sh_im, rem_re_next, rem_im_next;
    logic          ge_re, ge_im;
    logic [RW-1:0] rem_re_reg, rem_im_reg;
    logic [W:0]    low_re_reg, low_im_reg, q_re_reg, q_im_reg;
    logic [DW:0]   d2_reg;
    srif_flags_t   flags_reg;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        sh_re       = {in_rem_re[RW-2:0], in_low_re[W]};
        sh_im       = {in_rem_im[RW-2:0], in_low_im[W]};
        ge_re       = sh_re >= RW'(in_d2);
        ge_im       = sh_im >= RW'(in_d2);
        rem_re_next = ge_re ? sh_re - RW'(in_d2) : sh_re;
        rem_im_next = ge_im ? sh_im - RW'(in_d2) : sh_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            low_re_reg <= {in_low_re[W-1:0], 1'b0};
            low_im_reg <= {in_low_im[W-1:0], 1'b0};
            q_re_reg   <= {in_q_re[W-1:0], ge_re};
            q_im_reg   <= {in_q_im[W-1:0], ge_im};
            d2_reg     <= in_d2;
            flags_reg  <= in_flags;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_low_re = low_re_reg;
    assign out_low_im = low_im_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;
    assign out_d2     = d2_reg;
    assign out_flags  = flags_reg;

endmodule

[rtl/spectral_regularized_inverse_filter.sv]
// top level: regularized inverse filter, one frequency bin per transaction
// pipeline: 7 front stages, (SAMPLE_WIDTH+1) division cells and 1 output stage
// throughput: one bin per cycle while the output is not stalled; each division cell
//   resolves one quotient bit of both parts, so the chain length sets the latency, not the rate
// stages advance independently, so bubbles collapse under output backpressure
// reset: asynchronous active low, empties the pipeline, scale to all ones, beta^2 to zero
module spectral_regularized_inverse_filter #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // slave side: filter_real, filter_imag, signal_real, signal_imag (low bits up)
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,
    // master side: result_real, result_imag (low bits up)
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,
    // tuser: zero_denominator, saturated (low bit up)
    output logic [1:0]                                  m_tuser,
    // register port
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [2:0]                                  paddr,
    input  logic [srif_pkg::CFG_WIDTH-1:0]              pwdata,
    output logic [srif_pkg::CFG_WIDTH-1:0]              prdata,
    output logic                                        pready
);
    import srif_pkg::*;

    localparam int W        = SAMPLE_WIDTH;
    localparam int DW       = den_width(SAMPLE_WIDTH, FRACTION_BITS);
    localparam int RW       = DW + 2;
    localparam int CELLS    = W + 1;
    localparam int OUT_BITS = ((2*W+7)/8)*8;

    // configuration registers
    logic [CFG_WIDTH-1:0] scale_reg, beta_sq_reg;
    logic                 cfg_write;
    srif_reg_t            reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = srif_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= SCALE_RESET;
            beta_sq_reg <= BETA_SQ_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_SCALE:   scale_reg   <= pwdata;
                REG_BETA_SQ: beta_sq_reg <= pwdata;
                default:     scale_reg   <= scale_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SCALE:   prdata = scale_reg;
            REG_BETA_SQ: prdata = beta_sq_reg;
            default:     prdata = scale_reg;
        endcase
    end

    // links between the front end and the division cells; link 0 is the front output
    logic              lk_valid [0:CELLS];
    logic              lk_ready [0:CELLS];
    logic [RW-1:0]     lk_rem_re [0:CELLS];
    logic [RW-1:0]     lk_rem_im [0:CELLS];
    logic [W:0]        lk_low_re [0:CELLS];
    logic [W:0]        lk_low_im [0:CELLS];
    logic [W:0]        lk_q_re [0:CELLS];
    logic [W:0]        lk_q_im [0:CELLS];
    logic [DW:0]       lk_d2 [0:CELLS];
    srif_flags_t       lk_flags [0:CELLS];

    // quotient accumulators start empty
    assign lk_q_re[0] = '0;
    assign lk_q_im[0] = '0;

    srif_front #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (s_tvalid),
        .in_ready               (s_tready),
        .filter_real            (signed'(s_tdata[W-1:0])),
        .filter_imag            (signed'(s_tdata[2*W-1:W])),
        .signal_real            (signed'(s_tdata[3*W-1:2*W])),
        .signal_imag            (signed'(s_tdata[4*W-1:3*W])),
        .scale_factor           (scale_reg),
        .regularization_squared (beta_sq_reg),
        .out_valid              (lk_valid[0]),
        .out_ready              (lk_ready[0]),
        .rem_re                 (lk_rem_re[0]),
        .rem_im                 (lk_rem_im[0]),
        .low_re                 (lk_low_re[0]),
        .low_im                 (lk_low_im[0]),
        .d2                     (lk_d2[0]),
        .flags                  (lk_flags[0])
    );

    // chain of division cells, most significant quotient bit first
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        srif_div_cell #(
            .SAMPLE_WIDTH  (SAMPLE_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (lk_valid[k]),
            .in_ready   (lk_ready[k]),
            .in_rem_re  (lk_rem_re[k]),
            .in_rem_im  (lk_rem_im[k]),
            .in_low_re  (lk_low_re[k]),
            .in_low_im  (lk_low_im[k]),
            .in_q_re    (lk_q_re[k]),
            .in_q_im    (lk_q_im[k]),
            .in_d2      (lk_d2[k]),
            .in_flags   (lk_flags[k]),
            .out_valid  (lk_valid[k+1]),
            .out_ready  (lk_ready[k+1]),
            .out_rem_re (lk_rem_re[k+1]),
            .out_rem_im (lk_rem_im[k+1]),
            .out_low_re (lk_low_re[k+1]),
            .out_low_im (lk_low_im[k+1]),
            .out_q_re   (lk_q_re[k+1]),
            .out_q_im   (lk_q_im[k+1]),
            .out_d2     (lk_d2[k+1]),
            .out_flags  (lk_flags[k+1])
        );
    end

    // output stage: sign, saturation, zero-denominator override
    logic             out_valid_reg;
    logic             out_adv;
    logic [W-1:0]     res_re_reg, res_im_reg;
    logic             zero_reg, sat_reg;
    logic [W-1:0]     res_re_next, res_im_next;
    logic             zero_next, sat_next;
    logic [W:0]       lim_pos, lim_neg, q_re, q_im, qn_re, qn_im;
    logic             clip_re, clip_im;
    srif_flags_t      fl;

    assign out_adv          = !out_valid_reg || m_tready;
    assign lk_ready[CELLS]  = out_adv;

    always_comb
    begin
        fl      = lk_flags[CELLS];
        q_re    = lk_q_re[CELLS];
        q_im    = lk_q_im[CELLS];
        qn_re   = -q_re;
        qn_im   = -q_im;
        lim_pos = {2'b00, {(W-1){1'b1}}};
        lim_neg = {2'b01, {(W-1){1'b0}}};
        clip_re = fl.ovf_re || (q_re > (fl.neg_re ? lim_neg : lim_pos));
        clip_im = fl.ovf_im || (q_im > (fl.neg_im ? lim_neg : lim_pos));
        if (clip_re)
            res_re_next = fl.neg_re ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            res_re_next = fl.neg_re ? qn_re[W-1:0] : q_re[W-1:0];
        if (clip_im)
            res_im_next = fl.neg_im ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            res_im_next = fl.neg_im ? qn_im[W-1:0] : q_im[W-1:0];
        sat_next  = clip_re || clip_im;
        zero_next = fl.zero_den;
        // zero denominator: result forced to zero, no saturation
        if (fl.zero_den)
        begin
            res_re_next = '0;
            res_im_next = '0;
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= lk_valid[CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            zero_reg   <= zero_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BITS'({res_im_reg, res_re_reg});
    assign m_tuser  = {sat_reg, zero_reg};

endmodule

[tb/sv/tb_spectral_regularized_inverse_filter.sv]
// self-checking testbench for the regularized inverse filter
`timescale 1ns / 100ps

module tb_spectral_regularized_inverse_filter;
    import srif_pkg::*;

    localparam int SW = 32;
    localparam int FB = 16;
    // pipeline depth of the top level, with margin
    localparam int DRAIN_CYCLES = SW + 9 + 20;
    localparam int RAND_PER_PHASE = 215;
    localparam int NUM_PHASES = 6;

    // one restored bin as the block should deliver it
    typedef struct {
        logic [SW-1:0] res_re;
        logic [SW-1:0] res_im;
        logic          zero_den;
        logic          sat;
    } restored_bin_t;

    // holds the register copies and the bins still in flight
    class bin_scoreboard;
        logic [CFG_WIDTH-1:0] scale;
        logic [CFG_WIDTH-1:0] beta_sq;
        restored_bin_t        pending[$];
        int                   errors;

        function new();
            scale   = SCALE_RESET;
            beta_sq = BETA_SQ_RESET;
            errors  = 0;
        endfunction

        // |n| * scale * 2^FB / (den * 2^32), rounded half away from zero, saturated
        function logic [SW-1:0] scaled_quotient(input logic signed [127:0] n,
                                                input logic [127:0] den,
                                                inout logic sat);
            logic          neg;
            logic [127:0]  absn;
            logic [255:0]  mag;
            logic [255:0]  num;
            logic [255:0]  dvs;
            logic [255:0]  q;
            logic [255:0]  lim;
            neg  = n < 0;
            absn = neg ? -n : n;
            mag  = absn;
            num  = ((mag * scale) << (FB + 1)) + ({128'b0, den} << 32);
            dvs  = {128'b0, den} << 33;
            q    = num / dvs;
            lim  = neg ? (256'd1 << (SW - 1)) : ((256'd1 << (SW - 1)) - 1);
            if (q > lim)
            begin
                q   = lim;
                sat = 1'b1;
            end
            return neg ? -q[SW-1:0] : q[SW-1:0];
        endfunction

        // accepted input transaction: work out the restored bin
        function void note_bin(input logic signed [SW-1:0] hr, input logic signed [SW-1:0] hi,
                               input logic signed [SW-1:0] gr, input logic signed [SW-1:0] gi);
            logic signed [127:0] xr;
            logic signed [127:0] xi;
            logic signed [127:0] yr;
            logic signed [127:0] yi;
            logic signed [127:0] n_re;
            logic signed [127:0] n_im;
            logic [127:0]        den;
            restored_bin_t       e;
            xr   = hr;
            xi   = hi;
            yr   = gr;
            yi   = gi;
            n_re = xr * yr + xi * yi;
            n_im = xr * yi - xi * yr;
            den  = xr * xr + xi * xi + ({96'b0, beta_sq} << FB);
            e.sat = 1'b0;
            if (den == 0)
            begin
                e.res_re   = '0;
                e.res_im   = '0;
                e.zero_den = 1'b1;
            end
            else
            begin
                e.res_re   = scaled_quotient(n_re, den, e.sat);
                e.res_im   = scaled_quotient(n_im, den, e.sat);
                e.zero_den = 1'b0;
            end
            pending.push_back(e);
        endfunction

        // accepted output transaction against the oldest pending bin
        function void check_bin(input logic [2*SW-1:0] data, input logic [1:0] user);
            restored_bin_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction: data %h user %b", data, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[SW-1:0] !== e.res_re)
            begin
                $error("result_real: expected %h, got %h", e.res_re, data[SW-1:0]);
                errors++;
            end
            if (data[2*SW-1:SW] !== e.res_im)
            begin
                $error("result_imag: expected %h, got %h", e.res_im, data[2*SW-1:SW]);
                errors++;
            end
            if (user[0] !== e.zero_den)
            begin
                $error("zero_denominator: expected %b, got %b", e.zero_den, user[0]);
                errors++;
            end
            if (user[1] !== e.sat)
            begin
                $error("saturated: expected %b, got %b", e.sat, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // filter_real, filter_imag, signal_real, signal_imag (low bits up)
    logic [4*SW-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // result_real, result_imag (low bits up)
    logic [2*SW-1:0]      m_tdata;
    // zero_denominator, saturated (low bit up)
    logic [1:0]           m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [CFG_WIDTH-1:0] pwdata;
    logic [CFG_WIDTH-1:0] prdata;
    logic                 pready;

    bin_scoreboard sb = new();
    int            burst_left;
    bit            sending_done;

    spectral_regularized_inverse_filter #(
        .SAMPLE_WIDTH  (SW),
        .FRACTION_BITS (FB)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous fixed limit, far above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // register write: setup cycle then access cycle, keeps the predictor in step
    task automatic write_reg(input srif_reg_t idx, input logic [CFG_WIDTH-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_SCALE)
            sb.scale = value;
        else
            sb.beta_sq = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one input transaction; valid stays high inside a burst, gaps between bursts
    task automatic send_bin(input logic [SW-1:0] hr, input logic [SW-1:0] hi,
                            input logic [SW-1:0] gr, input logic [SW-1:0] gi);
        s_tvalid <= 1'b1;
        s_tdata  <= {gi, gr, hi, hr};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_bin(hr, hi, gr, gi);
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        else
            burst_left--;
    endtask

    // spread of magnitudes: full range, near one, tiny, and the extremes
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000)
                                              : -$urandom_range(0, 32'h0004_0000);
            3:    return $urandom_range(0, 1) ? $urandom_range(0, 255) : -$urandom_range(0, 255);
            4:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom) >>> $urandom_range(0, 30);
        endcase
    endfunction

    // stop sending, wait until every pending bin has come back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // receiver stall pattern: free running, random, or long stalls, switching now and then
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= (left % 16) < 4;
            endcase
        end
    end

    // output transactions
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_bin(m_tdata, m_tuser);
    end

    initial
    begin
        logic [CFG_WIDTH-1:0] scale_set[NUM_PHASES];
        logic [CFG_WIDTH-1:0] beta_set[NUM_PHASES];
        logic [SW-1:0]        hr;
        logic [SW-1:0]        hi;
        scale_set = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                      32'h0080_0000, 32'h1234_5678, 32'hFFFF_FFFF};
        beta_set  = '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
                      32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_0001};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        burst_left = 4;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed bins at reset settings
        send_bin(32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000);       // zero denominator
        send_bin(32'h0, 32'h0, 32'h0, 32'h0);                       // zero denominator, zero signal
        send_bin(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);       // unity filter
        send_bin(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'hFFFF_0000);
        send_bin(32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000); // saturate both ways
        send_bin(32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_bin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_bin(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_bin(32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);       // tiny quotients, rounding
        send_bin(32'h0000_0002, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF);
        send_bin(32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0001_0000);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                drain();
                write_reg(REG_SCALE, scale_set[ph]);
                write_reg(REG_BETA_SQ, beta_set[ph]);
                // a zero filter bin on every setting
                send_bin(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
            end
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    hr = '0;
                    hi = '0;
                end
                else
                begin
                    hr = pick_sample();
                    hi = pick_sample();
                end
                send_bin(hr, hi, pick_sample(), pick_sample());
            end
        end
        s_tvalid <= 1'b0;
        drain();

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
